/* hw/rtl/s5rp_pkg.sv */
// Shared types and codes for the SOCKS5 greeting and request parser.
// Holds event kinds, status codes, the event record and the configuration record.
// No dependencies.
`timescale 1ns / 1ps

package s5rp_pkg;

  // Event kinds reported on the result channel.
  typedef enum logic [1:0] {
    KIND_GREET = 2'd0,
    KIND_ADDR  = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  // Verdict codes.
  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_GREET_VER  = 4'd1,
    ST_NO_METHOD  = 4'd2,
    ST_REQ_VER    = 4'd3,
    ST_BAD_CMD    = 4'd4,
    ST_RSV        = 4'd5,
    ST_BAD_ATYP   = 4'd6,
    ST_ATYP_DENY  = 4'd7,
    ST_CMD_DENY   = 4'd8
  } status_e;

  // Protocol byte values.
  localparam logic [7:0] ATYP_IPV4   = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN = 8'h03;
  localparam logic [7:0] ATYP_IPV6   = 8'h04;
  localparam logic [7:0] CMD_MIN     = 8'h01;
  localparam logic [7:0] CMD_MAX     = 8'h03;
  localparam logic [7:0] RSV_VALUE   = 8'h00;
  localparam logic [7:0] IPV4_LEN    = 8'd4;
  localparam logic [7:0] IPV6_LEN    = 8'd16;

  // Configuration register indexes.
  localparam logic [1:0] CFG_VERSION   = 2'd0;
  localparam logic [1:0] CFG_METHOD    = 2'd1;
  localparam logic [1:0] CFG_COMMANDS  = 2'd2;
  localparam logic [1:0] CFG_ADDRTYPES = 2'd3;

  // Configuration reset values.
  localparam logic [7:0] CFG_VERSION_RST   = 8'h05;
  localparam logic [7:0] CFG_METHOD_RST    = 8'h00;
  localparam logic [2:0] CFG_COMMANDS_RST  = 3'b001;
  localparam logic [2:0] CFG_ADDRTYPES_RST = 3'b010;

  typedef struct packed {
    logic [7:0] version;
    logic [7:0] method;
    logic [2:0] commands;
    logic [2:0] addr_types;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    status_e     status;
    logic [1:0]  command;
    logic [2:0]  addr_type;
    logic [7:0]  addr_byte;
    logic [7:0]  addr_index;
    logic [7:0]  addr_length;
    logic [31:0] ipv4_address;
    logic [15:0] dest_port;
  } event_t;

endpackage

/* hw/rtl/socks5_request_parser.sv */
// Top level of the SOCKS5 greeting and request parser: input stage, configuration
// registers and result register around the parser core. Depends on s5rp_pkg and
// s5rp_parser_core.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake               Payload
//  input     in         in_valid_i / in_stall_o data_byte_i, conn_start_i
//  result    out        out_valid_o / out_stall_i event_kind_o .. dest_port_o
//  config    in         cfg_we_i                cfg_index_i, cfg_data_i
//
// One byte per cycle is sustained while out_stall_i is low. A byte is registered on
// acceptance, decoded by the parser core as it moves on, and its result is registered.
// The input stage stalls only while a result is held waiting on out_stall_i.
// Reset clears the parse state and loads the configuration defaults; no clearing pass.

module socks5_request_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        conn_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_kind_o,
  output logic [3:0]  status_o,
  output logic [1:0]  command_o,
  output logic [2:0]  addr_type_o,
  output logic [7:0]  addr_byte_o,
  output logic [7:0]  addr_index_o,
  output logic [7:0]  addr_length_o,
  output logic [31:0] ipv4_address_o,
  output logic [15:0] dest_port_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import s5rp_pkg::*;

  cfg_t       cfg_q;
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_start_q;
  logic       advance;
  logic       in_take;
  event_t     ev;
  event_t     out_q;
  logic       out_valid_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.version    <= CFG_VERSION_RST;
      cfg_q.method     <= CFG_METHOD_RST;
      cfg_q.commands   <= CFG_COMMANDS_RST;
      cfg_q.addr_types <= CFG_ADDRTYPES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_VERSION:   cfg_q.version    <= cfg_data_i;
        CFG_METHOD:    cfg_q.method     <= cfg_data_i;
        CFG_COMMANDS:  cfg_q.commands   <= cfg_data_i[2:0];
        CFG_ADDRTYPES: cfg_q.addr_types <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // The staged byte moves on when the result register is free or being drained.
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q  <= data_byte_i;
      s1_start_q <= conn_start_i;
    end
  end

  s5rp_parser_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (advance),
    .data_byte_i  (s1_byte_q),
    .conn_start_i (s1_start_q),
    .cfg_i        (cfg_q),
    .event_o      (ev)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ev.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev.valid) begin
      out_q <= ev;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = out_q.kind;
  assign status_o       = out_q.status;
  assign command_o      = out_q.command;
  assign addr_type_o    = out_q.addr_type;
  assign addr_byte_o    = out_q.addr_byte;
  assign addr_index_o   = out_q.addr_index;
  assign addr_length_o  = out_q.addr_length;
  assign ipv4_address_o = out_q.ipv4_address;
  assign dest_port_o    = out_q.dest_port;

  // The input side stalls only because a result is waiting on a stalled output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a held result");

  // A new event is never produced over a result that is still held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev.valid |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten");

  // A stalled staged byte is still there next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> s1_valid_q)
    else $error("staged byte lost while stalled");

endmodule

/* hw/rtl/s5rp_parser_core.sv */
// Parser state machine: holds the per-connection parse state and decodes one
// byte per take_i cycle into at most one event. Depends on s5rp_pkg.
`timescale 1ns / 1ps

module s5rp_parser_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  logic [7:0]      data_byte_i,
  input  logic            conn_start_i,
  input  s5rp_pkg::cfg_t  cfg_i,
  output s5rp_pkg::event_t event_o
);
  import s5rp_pkg::*;

  typedef enum logic [3:0] {
    PH_GVER, PH_NMETH, PH_METHODS, PH_RVER, PH_RCMD, PH_RRSV,
    PH_RATYP, PH_DLEN, PH_ADDR, PH_PORTH, PH_PORTL, PH_HALT
  } phase_e;

  phase_e      phase_q, phase_d, phase_eff;
  logic [7:0]  count_q, count_d, count_eff;
  logic [7:0]  left_q, left_d, left_eff, left_dec;
  logic        seen_q, seen_d, seen_eff;
  logic [1:0]  cmd_q, cmd_d, cmd_eff;
  logic [2:0]  atyp_q, atyp_d, atyp_eff;
  logic [7:0]  len_q, len_d, len_eff;
  logic [31:0] ipv4_q, ipv4_d, ipv4_eff;
  logic [15:0] port_q, port_d, port_eff;

  logic        emit;
  kind_e       ev_kind;
  status_e     ev_status;
  logic [7:0]  ev_ab, ev_ai;
  logic [31:0] ev_ip;
  logic [15:0] ev_port;
  logic        atyp_ok, cmd_ok;

  // A connection start restarts parsing from a cleared state on this same byte.
  always_comb begin
    if (conn_start_i) begin
      phase_eff = PH_GVER;
      count_eff = '0;
      left_eff  = '0;
      seen_eff  = 1'b0;
      cmd_eff   = '0;
      atyp_eff  = '0;
      len_eff   = '0;
      ipv4_eff  = '0;
      port_eff  = '0;
    end else begin
      phase_eff = phase_q;
      count_eff = count_q;
      left_eff  = left_q;
      seen_eff  = seen_q;
      cmd_eff   = cmd_q;
      atyp_eff  = atyp_q;
      len_eff   = len_q;
      ipv4_eff  = ipv4_q;
      port_eff  = port_q;
    end
  end

  assign left_dec = left_eff - 8'd1;

  // Permission checks made when the port is complete.
  always_comb begin
    unique case (atyp_eff)
      ATYP_IPV4[2:0]:   atyp_ok = cfg_i.addr_types[0];
      ATYP_DOMAIN[2:0]: atyp_ok = cfg_i.addr_types[1];
      default:          atyp_ok = cfg_i.addr_types[2];
    endcase
    unique case (cmd_eff)
      2'd1:    cmd_ok = cfg_i.commands[0];
      2'd2:    cmd_ok = cfg_i.commands[1];
      2'd3:    cmd_ok = cfg_i.commands[2];
      default: cmd_ok = 1'b0;
    endcase
  end

  // Per-byte decode.
  always_comb begin
    phase_d   = phase_eff;
    count_d   = count_eff;
    left_d    = left_eff;
    seen_d    = seen_eff;
    cmd_d     = cmd_eff;
    atyp_d    = atyp_eff;
    len_d     = len_eff;
    ipv4_d    = ipv4_eff;
    port_d    = port_eff;
    emit      = 1'b0;
    ev_kind   = KIND_GREET;
    ev_status = ST_OK;
    ev_ab     = '0;
    ev_ai     = '0;
    ev_ip     = '0;
    ev_port   = '0;
    unique case (phase_eff)
      PH_GVER: begin
        if (data_byte_i != cfg_i.version) begin
          phase_d = PH_HALT; emit = 1'b1; ev_kind = KIND_GREET; ev_status = ST_GREET_VER;
        end else begin
          phase_d = PH_NMETH;
        end
      end
      PH_NMETH: begin
        left_d = data_byte_i;
        seen_d = 1'b0;
        if (data_byte_i == 8'd0) begin
          phase_d = PH_HALT; emit = 1'b1; ev_kind = KIND_GREET; ev_status = ST_NO_METHOD;
        end else begin
          phase_d = PH_METHODS;
        end
      end
      PH_METHODS: begin
        left_d = left_dec;
        if (data_byte_i == cfg_i.method) seen_d = 1'b1;
        if (left_dec == 8'd0) begin
          emit    = 1'b1;
          ev_kind = KIND_GREET;
          if (!(seen_eff || data_byte_i == cfg_i.method)) begin
            phase_d = PH_HALT; ev_status = ST_NO_METHOD;
          end else begin
            phase_d = PH_RVER; ev_status = ST_OK;
          end
        end
      end
      PH_RVER: begin
        if (data_byte_i != cfg_i.version) begin
          phase_d = PH_HALT; emit = 1'b1; ev_kind = KIND_DONE; ev_status = ST_REQ_VER;
        end else begin
          phase_d = PH_RCMD;
        end
      end
      PH_RCMD: begin
        if (data_byte_i < CMD_MIN || data_byte_i > CMD_MAX) begin
          phase_d = PH_HALT; emit = 1'b1; ev_kind = KIND_DONE; ev_status = ST_BAD_CMD;
        end else begin
          cmd_d   = data_byte_i[1:0];
          phase_d = PH_RRSV;
        end
      end
      PH_RRSV: begin
        if (data_byte_i != RSV_VALUE) begin
          phase_d = PH_HALT; emit = 1'b1; ev_kind = KIND_DONE; ev_status = ST_RSV;
        end else begin
          phase_d = PH_RATYP;
        end
      end
      PH_RATYP: begin
        if (data_byte_i == ATYP_IPV4) begin
          atyp_d = ATYP_IPV4[2:0]; len_d = IPV4_LEN; count_d = '0; phase_d = PH_ADDR;
        end else if (data_byte_i == ATYP_DOMAIN) begin
          atyp_d = ATYP_DOMAIN[2:0]; phase_d = PH_DLEN;
        end else if (data_byte_i == ATYP_IPV6) begin
          atyp_d = ATYP_IPV6[2:0]; len_d = IPV6_LEN; count_d = '0; phase_d = PH_ADDR;
        end else begin
          phase_d = PH_HALT; emit = 1'b1; ev_kind = KIND_DONE; ev_status = ST_BAD_ATYP;
        end
      end
      PH_DLEN: begin
        len_d   = data_byte_i;
        count_d = '0;
        phase_d = (data_byte_i == 8'd0) ? PH_PORTH : PH_ADDR;
      end
      PH_ADDR: begin
        if (atyp_eff == ATYP_IPV4[2:0]) ipv4_d = {ipv4_eff[23:0], data_byte_i};
        count_d = count_eff + 8'd1;
        if (count_eff + 8'd1 == len_eff) phase_d = PH_PORTH;
        emit    = 1'b1;
        ev_kind = KIND_ADDR;
        ev_ab   = data_byte_i;
        ev_ai   = count_eff;
      end
      PH_PORTH: begin
        port_d  = {data_byte_i, 8'd0};
        phase_d = PH_PORTL;
      end
      PH_PORTL: begin
        port_d  = {port_eff[15:8], data_byte_i};
        phase_d = PH_HALT;
        emit    = 1'b1;
        ev_kind = KIND_DONE;
        ev_port = {port_eff[15:8], data_byte_i};
        ev_ip   = (atyp_eff == ATYP_IPV4[2:0]) ? ipv4_eff : 32'd0;
        if (!atyp_ok)     ev_status = ST_ATYP_DENY;
        else if (!cmd_ok) ev_status = ST_CMD_DENY;
        else              ev_status = ST_OK;
      end
      default: begin
        phase_d = PH_HALT;
      end
    endcase
  end

  // Event record; held fields are the values before this byte's update.
  always_comb begin
    event_o.valid        = take_i & emit;
    event_o.kind         = ev_kind;
    event_o.status       = ev_status;
    event_o.command      = cmd_eff;
    event_o.addr_type    = atyp_eff;
    event_o.addr_byte    = ev_ab;
    event_o.addr_index   = ev_ai;
    event_o.addr_length  = len_eff;
    event_o.ipv4_address = ev_ip;
    event_o.dest_port    = ev_port;
  end

  // Parse state advances only on a byte that is being processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_GVER;
      count_q <= '0;
      left_q  <= '0;
      seen_q  <= 1'b0;
      cmd_q   <= '0;
      atyp_q  <= '0;
      len_q   <= '0;
      ipv4_q  <= '0;
      port_q  <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      left_q  <= left_d;
      seen_q  <= seen_d;
      cmd_q   <= cmd_d;
      atyp_q  <= atyp_d;
      len_q   <= len_d;
      ipv4_q  <= ipv4_d;
      port_q  <= port_d;
    end
  end

  // Once halted, nothing is reported until a new connection starts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HALT && !conn_start_i) |-> !event_o.valid)
    else $error("event reported while parser is halted");

  // Address bytes always carry an ok status and an index below the length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (event_o.valid && event_o.kind == KIND_ADDR) |->
      (event_o.status == ST_OK && event_o.addr_index < event_o.addr_length))
    else $error("address event with bad status or index");

  // A request-end event always leaves the parser halted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && event_o.valid && event_o.kind == KIND_DONE) |=>
      (phase_q == PH_HALT))
    else $error("request end without halt");

endmodule

/* verif/socks5_request_parser_tb.sv */
// Self-checking testbench for the SOCKS5 greeting and request parser.
// A directed table and random connections are checked against a predictor kept here.
// Depends on s5rp_pkg and socks5_request_parser.
`timescale 1ns / 1ps

module socks5_request_parser_tb;
  import s5rp_pkg::*;

  localparam int TIMEOUT_NS   = 2_000_000;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int DIR_ROWS     = 28;

  // Parser phases of the predictor.
  typedef enum logic [3:0] {
    PS_GREET_VER, PS_NMETHODS, PS_METHODS, PS_REQ_VER, PS_REQ_CMD, PS_REQ_RSV,
    PS_REQ_ATYP, PS_DOMAIN_LEN, PS_ADDR, PS_PORT_HI, PS_PORT_LO, PS_HALT
  } parse_phase_e;

  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [1:0]  command;
    logic [2:0]  addr_type;
    logic [7:0]  addr_byte;
    logic [7:0]  addr_index;
    logic [7:0]  addr_length;
    logic [31:0] ipv4_address;
    logic [15:0] dest_port;
  } parse_event_t;

  // One row of the directed table; typed rows carry their own kind and status.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    bit         typed;
    bit         want;
    kind_e      kind;
    status_e    status;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        conn_start_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  event_kind_o;
  logic [3:0]  status_o;
  logic [1:0]  command_o;
  logic [2:0]  addr_type_o;
  logic [7:0]  addr_byte_o;
  logic [7:0]  addr_index_o;
  logic [7:0]  addr_length_o;
  logic [31:0] ipv4_address_o;
  logic [15:0] dest_port_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;

  // Predictor copy of the configuration registers.
  logic [7:0] cfg_version;
  logic [7:0] cfg_method;
  logic [2:0] cfg_commands;
  logic [2:0] cfg_addrtypes;

  // Predictor copy of the parse state.
  parse_phase_e prs_phase;
  logic [7:0]   prs_count;
  logic [7:0]   prs_methods_left;
  logic         prs_method_seen;
  logic [1:0]   prs_cmd;
  logic [2:0]   prs_atyp;
  logic [7:0]   prs_addr_len;
  logic [31:0]  prs_ipv4;
  logic [15:0]  prs_port;

  parse_event_t pending_events [$];
  parse_event_t got_event;
  dir_row_t     dir_tab [DIR_ROWS];
  int           mismatches  = 0;
  int           live_items  = 0;
  int           hold_left   = 0;
  bit           idle_on     = 1'b1;
  bit           rx_hold_req = 1'b0;

  socks5_request_parser u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .conn_start_i   (conn_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_kind_o   (event_kind_o),
    .status_o       (status_o),
    .command_o      (command_o),
    .addr_type_o    (addr_type_o),
    .addr_byte_o    (addr_byte_o),
    .addr_index_o   (addr_index_o),
    .addr_length_o  (addr_length_o),
    .ipv4_address_o (ipv4_address_o),
    .dest_port_o    (dest_port_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Global watchdog.
  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  // Return the parse state to the start of a connection.
  function automatic void clear_parse_state();
    prs_phase        = PS_GREET_VER;
    prs_count        = '0;
    prs_methods_left = '0;
    prs_method_seen  = 1'b0;
    prs_cmd          = '0;
    prs_atyp         = '0;
    prs_addr_len     = '0;
    prs_ipv4         = '0;
    prs_port         = '0;
  endfunction

  // Advance the predictor by one client byte; returns 1 when the byte yields an event.
  function automatic bit parse_byte(input logic [7:0] b, input logic cs,
                                    output parse_event_t ev);
    bit         hit;
    logic [2:0] at_bit;
    logic [2:0] cmd_bit;
    hit = 1'b0;
    ev  = '0;
    if (cs) clear_parse_state();
    case (prs_phase)
      PS_GREET_VER: begin
        if (b != cfg_version) begin
          hit = 1'b1; ev.kind = KIND_GREET; ev.status = ST_GREET_VER; prs_phase = PS_HALT;
        end else begin
          prs_phase = PS_NMETHODS;
        end
      end
      PS_NMETHODS: begin
        prs_methods_left = b;
        prs_method_seen  = 1'b0;
        if (b == 8'd0) begin
          hit = 1'b1; ev.kind = KIND_GREET; ev.status = ST_NO_METHOD; prs_phase = PS_HALT;
        end else begin
          prs_phase = PS_METHODS;
        end
      end
      PS_METHODS: begin
        if (b == cfg_method) prs_method_seen = 1'b1;
        prs_methods_left = prs_methods_left - 8'd1;
        if (prs_methods_left == 8'd0) begin
          hit = 1'b1;
          ev.kind = KIND_GREET;
          if (!prs_method_seen) begin
            ev.status = ST_NO_METHOD; prs_phase = PS_HALT;
          end else begin
            ev.status = ST_OK; prs_phase = PS_REQ_VER;
          end
        end
      end
      PS_REQ_VER: begin
        if (b != cfg_version) begin
          hit = 1'b1; ev.kind = KIND_DONE; ev.status = ST_REQ_VER; prs_phase = PS_HALT;
        end else begin
          prs_phase = PS_REQ_CMD;
        end
      end
      PS_REQ_CMD: begin
        if (b < CMD_MIN || b > CMD_MAX) begin
          hit = 1'b1; ev.kind = KIND_DONE; ev.status = ST_BAD_CMD; prs_phase = PS_HALT;
        end else begin
          prs_cmd = b[1:0]; prs_phase = PS_REQ_RSV;
        end
      end
      PS_REQ_RSV: begin
        if (b != RSV_VALUE) begin
          hit = 1'b1; ev.kind = KIND_DONE; ev.status = ST_RSV; prs_phase = PS_HALT;
        end else begin
          prs_phase = PS_REQ_ATYP;
        end
      end
      PS_REQ_ATYP: begin
        if (b == ATYP_IPV4 || b == ATYP_IPV6) begin
          prs_atyp     = b[2:0];
          prs_addr_len = (b == ATYP_IPV4) ? IPV4_LEN : IPV6_LEN;
          prs_count    = '0;
          prs_phase    = PS_ADDR;
        end else if (b == ATYP_DOMAIN) begin
          prs_atyp  = b[2:0];
          prs_phase = PS_DOMAIN_LEN;
        end else begin
          hit = 1'b1; ev.kind = KIND_DONE; ev.status = ST_BAD_ATYP; prs_phase = PS_HALT;
        end
      end
      PS_DOMAIN_LEN: begin
        prs_addr_len = b;
        prs_count    = '0;
        // A zero-length domain skips straight to the port.
        prs_phase    = (b == 8'd0) ? PS_PORT_HI : PS_ADDR;
      end
      PS_ADDR: begin
        hit = 1'b1;
        ev.kind       = KIND_ADDR;
        ev.status     = ST_OK;
        ev.addr_byte  = b;
        ev.addr_index = prs_count;
        if (prs_atyp == ATYP_IPV4[2:0]) prs_ipv4 = {prs_ipv4[23:0], b};
        prs_count = prs_count + 8'd1;
        if (prs_count == prs_addr_len) prs_phase = PS_PORT_HI;
      end
      PS_PORT_HI: begin
        prs_port  = {b, 8'h00};
        prs_phase = PS_PORT_LO;
      end
      PS_PORT_LO: begin
        prs_port = {prs_port[15:8], b};
        at_bit   = (prs_atyp == ATYP_IPV4[2:0])   ? 3'b001 :
                   (prs_atyp == ATYP_DOMAIN[2:0]) ? 3'b010 : 3'b100;
        cmd_bit  = 3'b001 << (prs_cmd - 2'd1);
        hit = 1'b1;
        ev.kind = KIND_DONE;
        // Address type denial wins over command denial.
        if ((cfg_addrtypes & at_bit) == 3'b000)     ev.status = ST_ATYP_DENY;
        else if ((cfg_commands & cmd_bit) == 3'b000) ev.status = ST_CMD_DENY;
        else                                          ev.status = ST_OK;
        ev.ipv4_address = (prs_atyp == ATYP_IPV4[2:0]) ? prs_ipv4 : 32'd0;
        ev.dest_port    = prs_port;
        prs_phase       = PS_HALT;
      end
      default: ;
    endcase
    if (hit) begin
      ev.command     = prs_cmd;
      ev.addr_type   = prs_atyp;
      ev.addr_length = prs_addr_len;
    end
    return hit;
  endfunction

  // Offer one byte, wait for the transaction and record what it should produce.
  task automatic send_byte(input logic [7:0] b, input logic cs, input bit typed,
                           input bit want, input kind_e k, input status_e s);
    parse_event_t ev;
    bit           hit;
    if (idle_on && $urandom_range(0, 99) < 10) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    conn_start_i <= cs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (cs || prs_phase != PS_HALT) live_items++;
    hit = parse_byte(b, cs, ev);
    if (typed) begin
      hit = want; ev.kind = k; ev.status = s;
    end
    if (hit) pending_events.push_back(ev);
  endtask

  // Build one connection; mostly well formed, sometimes with one byte corrupted.
  // A non-negative dom_len forces a clean domain request of that length.
  task automatic send_connection(input int dom_len);
    logic [8:0] seq [$];
    int         n_meth;
    int         pick;
    int         alen;
    int         sel;
    bit         bad;
    bad    = (dom_len < 0) && ($urandom_range(0, 99) < 25);
    n_meth = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
    pick   = $urandom_range(0, n_meth - 1);
    seq.push_back({1'b1, cfg_version});
    seq.push_back({1'b0, 8'(n_meth)});
    for (int i = 0; i < n_meth; i++) begin
      seq.push_back({1'b0, (i == pick) ? cfg_method : 8'($urandom)});
    end
    seq.push_back({1'b0, cfg_version});
    seq.push_back({1'b0, 8'($urandom_range(CMD_MIN, CMD_MAX))});
    seq.push_back({1'b0, RSV_VALUE});
    sel = (dom_len >= 0) ? 1 : $urandom_range(0, 2);
    case (sel)
      0: begin
        seq.push_back({1'b0, ATYP_IPV4});
        alen = IPV4_LEN;
      end
      1: begin
        seq.push_back({1'b0, ATYP_DOMAIN});
        if (dom_len >= 0) alen = dom_len;
        else if ($urandom_range(0, 49) == 0) alen = $urandom_range(0, 255);
        else alen = $urandom_range(0, 8);
        seq.push_back({1'b0, 8'(alen)});
      end
      default: begin
        seq.push_back({1'b0, ATYP_IPV6});
        alen = IPV6_LEN;
      end
    endcase
    for (int i = 0; i < alen + 2; i++) seq.push_back({1'b0, 8'($urandom)});
    if (bad) begin
      pick = $urandom_range(0, seq.size() - 1);
      seq[pick] = {1'($urandom_range(0, 3) == 0), 8'($urandom)};
    end
    // Trailing noise that the block should ignore.
    if ($urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(1, 2)) seq.push_back({1'b0, 8'($urandom)});
    end
    foreach (seq[i]) send_byte(seq[i][7:0], seq[i][8], 1'b0, 1'b0, KIND_GREET, ST_OK);
  endtask

  task automatic run_items(input int n);
    int target;
    target = live_items + n;
    while (live_items < target) send_connection(-1);
  endtask

  // Stop offering bytes until every pending event has arrived and the pipe is empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      CFG_VERSION:   cfg_version   = val;
      CFG_METHOD:    cfg_method    = val;
      CFG_COMMANDS:  cfg_commands  = val[2:0];
      CFG_ADDRTYPES: cfg_addrtypes = val[2:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [7:0] v, input logic [7:0] m,
                             input logic [7:0] c, input logic [7:0] a);
    write_reg(CFG_VERSION, v);
    write_reg(CFG_METHOD, m);
    write_reg(CFG_COMMANDS, c);
    write_reg(CFG_ADDRTYPES, a);
    cfg_we_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when requested.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= idle_on && ($urandom_range(0, 99) < 10);
      end
    end
  end

  // Compare each result transaction with the oldest pending event.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        $error("result with nothing pending: kind %0d status %0d", event_kind_o, status_o);
        mismatches++;
      end else begin
        got_event = pending_events.pop_front();
        check_field("event_kind", 32'(got_event.kind), 32'(event_kind_o));
        check_field("status", 32'(got_event.status), 32'(status_o));
        check_field("command", 32'(got_event.command), 32'(command_o));
        check_field("addr_type", 32'(got_event.addr_type), 32'(addr_type_o));
        check_field("addr_byte", 32'(got_event.addr_byte), 32'(addr_byte_o));
        check_field("addr_index", 32'(got_event.addr_index), 32'(addr_index_o));
        check_field("addr_length", 32'(got_event.addr_length), 32'(addr_length_o));
        check_field("ipv4_address", got_event.ipv4_address, ipv4_address_o);
        check_field("dest_port", 32'(got_event.dest_port), 32'(dest_port_o));
      end
    end
  end

  // Main sequence.
  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_byte_i  = '0;
    conn_start_i = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CFG_VERSION;
    cfg_data_i   = '0;
    cfg_version   = CFG_VERSION_RST;
    cfg_method    = CFG_METHOD_RST;
    cfg_commands  = CFG_COMMANDS_RST;
    cfg_addrtypes = CFG_ADDRTYPES_RST;
    clear_parse_state();

    // Directed table under the reset configuration.
    dir_tab = '{
      '{8'h04, 1'b1, 1'b1, 1'b1, KIND_GREET, ST_GREET_VER},  // wrong greeting version
      '{8'h00, 1'b0, 1'b1, 1'b0, KIND_GREET, ST_OK},         // ignored after an error
      '{8'h05, 1'b1, 1'b1, 1'b0, KIND_GREET, ST_OK},
      '{8'h00, 1'b0, 1'b1, 1'b1, KIND_GREET, ST_NO_METHOD},  // zero methods offered
      '{8'h05, 1'b1, 1'b1, 1'b0, KIND_GREET, ST_OK},
      '{8'h01, 1'b0, 1'b1, 1'b0, KIND_GREET, ST_OK},
      '{8'h00, 1'b0, 1'b1, 1'b1, KIND_GREET, ST_OK},
      '{8'h05, 1'b0, 1'b0, 1'b0, KIND_GREET, ST_OK},
      '{8'h01, 1'b0, 1'b0, 1'b0, KIND_GREET, ST_OK},         // connect
      '{8'h00, 1'b0, 1'b0, 1'b0, KIND_GREET, ST_OK},
      '{8'h03, 1'b0, 1'b0, 1'b0, KIND_GREET, ST_OK},         // domain name
      '{8'h00, 1'b0, 1'b0, 1'b0, KIND_GREET, ST_OK},         // zero-length domain
      '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_GREET, ST_OK},
      '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_GREET, ST_OK},         // request done, port FFFF
      '{8'hFF, 1'b0, 1'b1, 1'b0, KIND_GREET, ST_OK},         // ignored after a finish
      '{8'h05, 1'b1, 1'b1, 1'b0, KIND_GREET, ST_OK},
      '{8'h01, 1'b0, 1'b1, 1'b0, KIND_GREET, ST_OK},
      '{8'h00, 1'b0, 1'b1, 1'b1, KIND_GREET, ST_OK},
      '{8'h05, 1'b0, 1'b0, 1'b0, KIND_GREET, ST_OK},
      '{8'h02, 1'b0, 1'b0, 1'b0, KIND_GREET, ST_OK},         // bind, not permitted
      '{8'h00, 1'b0, 1'b0, 1'b0, KIND_GREET, ST_OK},
      '{8'h01, 1'b0, 1'b0, 1'b0, KIND_GREET, ST_OK},         // IPv4, not permitted
      '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_GREET, ST_OK},
      '{8'h00, 1'b0, 1'b0, 1'b0, KIND_GREET, ST_OK},
      '{8'h80, 1'b0, 1'b0, 1'b0, KIND_GREET, ST_OK},
      '{8'h01, 1'b0, 1'b0, 1'b0, KIND_GREET, ST_OK},
      '{8'h00, 1'b0, 1'b0, 1'b0, KIND_GREET, ST_OK},
      '{8'h00, 1'b0, 1'b1, 1'b1, KIND_DONE,  ST_ATYP_DENY}   // type denial wins
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[r]) begin
      send_byte(dir_tab[r].data, dir_tab[r].start, dir_tab[r].typed, dir_tab[r].want,
                dir_tab[r].kind, dir_tab[r].status);
    end
    run_items(80);

    // Everything permitted, masks written wider than the registers, no idling.
    settle();
    load_config(8'h05, 8'h00, 8'hFF, 8'hFF);
    idle_on = 1'b0;
    run_items(80);
    idle_on = 1'b1;

    // Low extremes: version zero, method FF, nothing permitted.
    settle();
    load_config(8'h00, 8'hFF, 8'h00, 8'h00);
    run_items(80);

    // High version; a long receiver hold-off while a long domain is offered.
    settle();
    load_config(8'hFF, 8'($urandom), 8'($urandom), 8'($urandom));
    rx_hold_req = 1'b1;
    send_connection(48);
    run_items(80);

    // Fully random setting.
    settle();
    load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_items(80);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
